/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL (included by blpm_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/blpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package blpm_pkg;

	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_END      = 2'd1;
	localparam logic [1:0] OP_PEAK_CLR = 2'd2;

	localparam logic [31:0] OVERRUN_LIMIT = 32'd1000;
	localparam logic [31:0] LOAD_MAX      = 32'hFFFF_FFFF;
	localparam logic [31:0] BUDGET_RESET  = 32'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] cycle_stamp;
	} in_t;

	typedef struct packed {
		logic [31:0] load_last;
		logic [31:0] load_peak;
		logic [31:0] overrun_total;
	} out_t;

	typedef struct packed {
		logic accept;
		logic mul_load;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_is_end;
		logic cnt_last;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/blpm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module blpm_datapath #(
	parameter int STAMP_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire blpm_pkg::in_t  in_data,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	input  wire blpm_pkg::cmd_t cmd,
	output blpm_pkg::sts_t      sts,
	output blpm_pkg::out_t      out_data
);
	import blpm_pkg::*;

	localparam int DW = STAMP_WIDTH + 10;
	localparam int XW = DW + 32;
	localparam int CW = $clog2(DW);

	logic [1:0]             op_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	logic [STAMP_WIDTH-1:0] start_q;
	logic [31:0]            last_q;
	logic [31:0]            peak_q;
	logic [31:0]            ovr_q;
	logic [31:0]            budget_q;
	logic [31:0]            rem_q;
	logic [DW-1:0]          dvd_q;
	logic [CW-1:0]          cnt_q;
	out_t                   out_q;

	logic [STAMP_WIDTH-1:0] elapsed;
	logic [DW-1:0]          ex;
	logic [DW-1:0]          scaled;
	logic [33:0]            trial;
	logic                   qbit;
	logic [XW-1:0]          qx;
	logic [31:0]            load;
	logic [31:0]            last_d;
	logic [31:0]            peak_d;
	logic [31:0]            ovr_d;

	assign elapsed = stamp_q - start_q;
	assign ex      = DW'(elapsed);
	// x1000 = x1024 - x32 + x8
	assign scaled  = (ex << 10) - (ex << 5) + (ex << 3);

	assign trial = {1'b0, rem_q, dvd_q[DW-1]} - {2'b00, budget_q};
	assign qbit  = ~trial[33];

	assign qx   = XW'(dvd_q);
	assign load = ((budget_q == 32'd0) || (|qx[XW-1:32])) ? LOAD_MAX : qx[31:0];

	always_comb begin
		last_d = last_q;
		peak_d = peak_q;
		ovr_d  = ovr_q;
		case (op_q)
			OP_END: begin
				last_d = load;
				if (load > peak_q) peak_d = load;
				if (load > OVERRUN_LIMIT) ovr_d = ovr_q + 32'd1;
			end
			OP_PEAK_CLR: begin
				peak_d = last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			last_q   <= '0;
			peak_q   <= '0;
			ovr_q    <= '0;
			budget_q <= BUDGET_RESET;
		end else begin
			if (cfg_we) budget_q <= cfg_wdata;
			if (cmd.commit) begin
				if (op_q == OP_START) start_q <= stamp_q;
				last_q <= last_d;
				peak_q <= peak_d;
				ovr_q  <= ovr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_data.op;
			stamp_q <= STAMP_WIDTH'(in_data.cycle_stamp);
		end
		if (cmd.mul_load) begin
			dvd_q <= scaled;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DW-2:0], qbit};
			rem_q <= qbit ? trial[31:0] : {rem_q[30:0], dvd_q[DW-1]};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.commit) begin
			out_q.load_last     <= last_d;
			out_q.load_peak     <= peak_d;
			out_q.overrun_total <= ovr_d;
		end
	end

	assign sts.in_is_end = (in_data.op == OP_END);
	assign sts.cnt_last  = (cnt_q == CW'(DW - 1));
	assign out_data      = out_q;

endmodule
`default_nettype wire

/* hdl/blpm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module blpm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire blpm_pkg::sts_t sts,
	output blpm_pkg::cmd_t      cmd
);
	import blpm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t st_q, st_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		st_d         = st_q;
		cmd.accept   = 1'b0;
		cmd.mul_load = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					st_d = sts.in_is_end ? S_MUL : S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				st_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.cnt_last) st_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`AST_IMPL(a_commit_free, clk, arst_n, cmd.commit, (!out_valid_q || out_ready), "commit into busy slot")
	`AST_NEXT(a_div_to_fin, clk, arst_n, (st_q == S_DIV) && sts.cnt_last, st_q == S_FIN, "divider did not finish")
	`AST_NEXT(a_end_to_mul, clk, arst_n, cmd.accept && sts.in_is_end, st_q == S_MUL, "end event skipped divide")

endmodule
`default_nettype wire

/* hdl/block_load_permille_monitor.sv */
// Block load monitor, permille of a cycle budget.
// Input channel (in_valid/in_ready/in_data): one event per transfer, op is
// block start, block end or peak clear, with a cycle counter stamp.
// Output channel (out_valid/out_ready/out_data): one transfer per event with
// last load, peak load and overrun count after that event.
// cfg_we/cfg_wdata write the cycle budget; write only while idle.
// A block end passes through a scale step, STAMP_WIDTH+10 radix-2 divide
// steps and an update step before its result is loaded; other events go
// straight to the update step. A new event is taken the cycle after the
// previous result is loaded into the output register, so the block does not
// accept an event while the previous one is still in progress.
// A held result does not block acceptance of the next event; a finished
// event waits in the update cycle while the output register is still full.
// Reset clears the metrics and start stamp, sets the budget to 1 and empties
// the output register.
`timescale 1ns / 1ps
`default_nettype none
module block_load_permille_monitor #(
	parameter int STAMP_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire blpm_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output blpm_pkg::out_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata
);
	import blpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	blpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	blpm_datapath #(
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* tb/tb_block_load_permille_monitor.sv */
`timescale 1ns / 1ps
module tb_block_load_permille_monitor;
	import blpm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit          cfg;
		logic [31:0] val;
		logic [1:0]  op;
		bit          chk;
		out_t        res;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// predictor state
	logic [31:0] mark_stamp = '0;
	logic [31:0] recent_load = '0;
	logic [31:0] peak_permille = '0;
	logic [31:0] overrun_cnt = '0;
	logic [31:0] budget_reg = BUDGET_RESET;

	out_t  metrics_q[$];
	step_t directed_q[$];
	int    gap_pct = 15;
	int    stall_pct = 51;
	int    fails = 0;
	int    cycle_cnt = 0;

	block_load_permille_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] permille_of(logic [31:0] span, logic [31:0] budget);
		logic [63:0] q;
		if (budget == '0)
			return LOAD_MAX;
		q = ({32'd0, span} * 64'd1000) / {32'd0, budget};
		if (q > {32'd0, LOAD_MAX})
			return LOAD_MAX;
		return q[31:0];
	endfunction

	function automatic out_t step_metrics(in_t ev);
		logic [31:0] load;
		out_t res;
		case (ev.op)
			OP_START: begin
				mark_stamp = ev.cycle_stamp;
			end
			OP_END: begin
				load = permille_of(ev.cycle_stamp - mark_stamp, budget_reg);
				recent_load = load;
				if (load > peak_permille)
					peak_permille = load;
				if (load > OVERRUN_LIMIT)
					overrun_cnt = overrun_cnt + 32'd1;
			end
			OP_PEAK_CLR: begin
				peak_permille = recent_load;
			end
			default: begin
			end
		endcase
		res.load_last = recent_load;
		res.load_peak = peak_permille;
		res.overrun_total = overrun_cnt;
		return res;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer, valid left high
	task automatic send_event(logic [1:0] op, logic [31:0] stamp, bit chk, out_t fixed);
		in_t ev;
		out_t predicted;
		ev.op = op;
		ev.cycle_stamp = stamp;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		do @(posedge clk); while (!in_ready);
		predicted = step_metrics(ev);
		metrics_q.push_back(chk ? fixed : predicted);
		@(negedge clk);
	endtask

	task automatic quiesce(int pause);
		in_valid <= 1'b0;
		while (metrics_q.size() != 0)
			@(negedge clk);
		repeat (pause) @(negedge clk);
	endtask

	task automatic set_budget(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		budget_reg = v;
	endtask

	function automatic void add_row(bit cfg, logic [31:0] val, logic [1:0] op, bit chk,
			logic [31:0] l, logic [31:0] p, logic [31:0] o);
		step_t s;
		s.cfg = cfg;
		s.val = val;
		s.op = op;
		s.chk = chk;
		s.res.load_last = l;
		s.res.load_peak = p;
		s.res.overrun_total = o;
		directed_q.push_back(s);
	endfunction

	function automatic logic [31:0] pick_span();
		logic [63:0] k;
		logic [63:0] wide;
		case ($urandom_range(3))
			0: begin
				k = $urandom_range(800, 1200);
				wide = ({32'd0, budget_reg} * k) / 64'd1000;
				return wide[31:0];
			end
			1: return $urandom_range(0, 2000);
			2: return $urandom();
			default: return budget_reg + $urandom_range(0, 3) - 32'd2;
		endcase
	endfunction

	task automatic run_segment(int n);
		int cnt;
		int r;
		logic [31:0] s;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(99);
			s = $urandom();
			if (r < 70) begin
				send_event(OP_START, s, 1'b0, '0);
				send_event(OP_END, s + pick_span(), 1'b0, '0);
				cnt += 2;
			end else begin
				if (r < 78)
					send_event(OP_PEAK_CLR, s, 1'b0, '0);
				else if (r < 84)
					send_event(OP_SPARE, s, 1'b0, '0);
				else if (r < 92)
					send_event(OP_END, s, 1'b0, '0);
				else
					send_event(OP_START, s, 1'b0, '0);
				cnt++;
			end
		end
	endtask

	// receiver stalls
	always @(negedge clk)
		out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (metrics_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				want = metrics_q.pop_front();
				if (out_data.load_last !== want.load_last) begin
					$error("load_last: expected %0d, got %0d", want.load_last, out_data.load_last);
					fails++;
				end
				if (out_data.load_peak !== want.load_peak) begin
					$error("load_peak: expected %0d, got %0d", want.load_peak, out_data.load_peak);
					fails++;
				end
				if (out_data.overrun_total !== want.overrun_total) begin
					$error("overrun_total: expected %0d, got %0d", want.overrun_total,
						out_data.overrun_total);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("block_load_permille_monitor regression: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] budget;
		// budget 1 from reset
		add_row(0, 32'd0,         OP_SPARE,    1, 32'd0,        32'd0,        32'd0);
		add_row(0, 32'd0,         OP_END,      1, 32'd0,        32'd0,        32'd0);
		add_row(0, 32'hFFFF_FFFF, OP_START,    1, 32'd0,        32'd0,        32'd0);
		add_row(0, 32'd0,         OP_END,      1, 32'd1000,     32'd1000,     32'd0);
		add_row(0, 32'd1,         OP_END,      1, 32'd2000,     32'd2000,     32'd1);
		add_row(0, 32'd0,         OP_START,    1, 32'd2000,     32'd2000,     32'd1);
		add_row(0, 32'hFFFF_FFFF, OP_END,      1, LOAD_MAX,     LOAD_MAX,     32'd2);
		add_row(0, 32'd100,       OP_START,    1, LOAD_MAX,     LOAD_MAX,     32'd2);
		add_row(0, 32'd100,       OP_END,      1, 32'd0,        LOAD_MAX,     32'd2);
		add_row(0, 32'd0,         OP_PEAK_CLR, 1, 32'd0,        32'd0,        32'd2);
		add_row(0, 32'hFFFF_FFFF, OP_SPARE,    1, 32'd0,        32'd0,        32'd2);
		// zero budget saturates, then budgets FFFF_FFFF and 1000
		add_row(1, 32'd0,         OP_START,    0, '0,           '0,           '0);
		add_row(0, 32'd5,         OP_END,      1, LOAD_MAX,     LOAD_MAX,     32'd3);
		add_row(0, 32'd0,         OP_START,    1, LOAD_MAX,     LOAD_MAX,     32'd3);
		add_row(1, 32'hFFFF_FFFF, OP_START,    0, '0,           '0,           '0);
		add_row(0, 32'hFFFF_FFFF, OP_END,      1, 32'd1000,     LOAD_MAX,     32'd3);
		add_row(0, 32'hFFFF_FFFE, OP_END,      1, 32'd999,      LOAD_MAX,     32'd3);
		add_row(0, 32'd0,         OP_PEAK_CLR, 1, 32'd999,      32'd999,      32'd3);
		add_row(1, 32'd1000,      OP_START,    0, '0,           '0,           '0);
		add_row(0, 32'd10,        OP_START,    1, 32'd999,      32'd999,      32'd3);
		add_row(0, 32'd1010,      OP_END,      1, 32'd1000,     32'd1000,     32'd3);
		add_row(0, 32'd1011,      OP_END,      1, 32'd1001,     32'd1001,     32'd4);
		add_row(0, 32'h8000_0000, OP_END,      0, '0,           '0,           '0);
		add_row(0, 32'h5555_AAAA, OP_PEAK_CLR, 0, '0,           '0,           '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_q[i]) begin
			if (directed_q[i].cfg) begin
				quiesce(4);
				set_budget(directed_q[i].val);
			end else begin
				send_event(directed_q[i].op, directed_q[i].val, directed_q[i].chk,
					directed_q[i].res);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 15 : (ph == 1) ? 51 : 0;
			stall_pct = (ph == 0) ? 51 : (ph == 1) ? 15 : 0;
			for (int sg = 0; sg < 8; sg++) begin
				case (sg)
					0: budget = 32'd1;
					1: budget = 32'd0;
					2: budget = 32'hFFFF_FFFF;
					3: budget = $urandom_range(1, 64);
					4: budget = $urandom_range(1000, 100000);
					5: budget = $urandom();
					6: budget = 32'd1000;
					default: budget = $urandom_range(48000, 480000);
				endcase
				quiesce(4);
				set_budget(budget);
				run_segment(50);
			end
		end

		quiesce(50);
		if (fails == 0)
			$display("block_load_permille_monitor regression: pass");
		else
			$display("block_load_permille_monitor regression: fail");
		$finish;
	end

endmodule
